### rtl/dpd_pkg.sv
`timescale 1ns / 1ps
package dpd_pkg;

   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int CFG_W = 13;

   // memory word: {pixel, dark mark one row up, dark mark two rows up}
   localparam int MEM_W = PIX_W + 2;

   // configuration register indexes (byte address 4*index)
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CH_W-1:0]  THRESH_RESET = 8'd50;

   localparam logic [PIX_W-1:0] BLACK_PIXEL = 24'h00_0000;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic            last_of_run;
      logic            last_of_frame;
   } result_type;

   // window layout: column k at bits 3k..3k+2, bit 0 of a column is two rows up
   function automatic logic [PIX_W-1:0] dilate_pixel(logic [PIX_W-1:0] pix,
                                                     logic [8:0] win);
      logic [PIX_W-1:0] res;
      res = pix;
      if (!win[4] && (win != 9'd0)) begin
         res = BLACK_PIXEL;
      end
      return res;
   endfunction

endpackage

### rtl/dpd_req_if.sv
`timescale 1ns / 1ps
interface dpd_req_if import dpd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red_in;
   logic [CH_W-1:0] green_in;
   logic [CH_W-1:0] blue_in;
   logic            flush;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   output flush, input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 input flush, output ready);
endinterface

### rtl/dpd_rsp_if.sv
`timescale 1ns / 1ps
interface dpd_rsp_if import dpd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red_out;
   logic [CH_W-1:0] green_out;
   logic [CH_W-1:0] blue_out;
   logic            last_of_run;
   logic            last_of_frame;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output last_of_run, output last_of_frame, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input last_of_run, input last_of_frame, output ready);
endinterface

### rtl/dpd_ram.sv
`timescale 1ns / 1ps
module dpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dark_pixel_dilate_3x3_core.sv
`timescale 1ns / 1ps
// An input beat is registered into stage 1, whose result beats are registered into the
// result queue. Throughput: one input beat per clock while the queue has room; the
// single-port-pair line store is read in the accept cycle and written back in the next.
// Reset (synchronous, active high): clears configuration to defaults, position,
// window, pixel holds and the result queue; the line store needs no clearing pass.
module dark_pixel_dilate_3x3_core import dpd_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   dpd_req_if.sink     req,
   dpd_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // column index bits, and a width wide enough for both the register and MAX_WIDTH
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int RW = CFG_W + 1;

   // result queue: room for the item in stage 1 plus the one being accepted
   localparam int QDEPTH = 8;
   localparam int QW     = $clog2(QDEPTH);

   typedef struct packed {
      logic [CW-1:0]    col;
      logic [PIX_W-1:0] pix;
      logic             cur;
      logic             ge1;
      logic             ge2;
      logic             col_zero;
      logic             last_col;
      logic             last_frame;
   } stage_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CH_W-1:0]  thresh_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CFG_W-1:0];
            REG_THRESH: thresh_ff <= csr_pwdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH:  csr_prdata = {{(32-CFG_W){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(32-CFG_W){1'b0}}, height_ff};
         REG_THRESH: csr_prdata = {{(32-CH_W){1'b0}}, thresh_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage 0: position tracking, dark test, line-store read
   // ------------------------------------------------------------------
   logic [CW-1:0]    col_pos_ff, col_pos_in;
   logic [CFG_W-1:0] row_pos_ff, row_pos_in;
   logic [EW-1:0]    w_ext, w_eff;
   logic [CFG_W-1:0] h_eff;
   logic [CW-1:0]    col_norm;
   logic [RW-1:0]    row_tmp, row_next;
   logic [CFG_W-1:0] row_norm;
   logic             active;
   logic             last_col;
   logic [PIX_W-1:0] pix_s0;
   logic             cur_s0;
   logic             accept;
   logic [QW:0]      count_ff;
   stage_type        s0;

   assign accept    = req.valid && req.ready;
   assign req.ready = (count_ff <= (QW+1)'(QDEPTH - 4));

   always_comb begin
      // a zero size acts as one, a width past the store acts as the store depth
      w_ext = EW'(width_ff);
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      h_eff = (height_ff == '0) ? CFG_W'(1) : height_ff;

      // a position left beyond a shrunk frame wraps first
      if (EW'(col_pos_ff) >= w_eff) begin
         col_norm = '0;
         row_tmp  = RW'(row_pos_ff) + RW'(1);
      end else begin
         col_norm = col_pos_ff;
         row_tmp  = RW'(row_pos_ff);
      end
      row_norm = (row_tmp > RW'(h_eff)) ? '0 : row_tmp[CFG_W-1:0];

      // rows at or past the height are the flush row: no pixel, never dark
      active   = row_norm < h_eff;
      pix_s0   = active ? {req.red_in, req.green_in, req.blue_in} : BLACK_PIXEL;
      cur_s0   = active && (req.red_in < thresh_ff) && (req.green_in < thresh_ff)
                 && (req.blue_in < thresh_ff);
      last_col = (EW'(col_norm) == (w_eff - EW'(1)));

      row_next = RW'(row_norm) + RW'(1);
      if (last_col) begin
         col_pos_in = '0;
         row_pos_in = (row_next > RW'(h_eff)) ? '0 : row_next[CFG_W-1:0];
      end else begin
         col_pos_in = col_norm + CW'(1);
         row_pos_in = row_norm;
      end

      s0.col        = col_norm;
      s0.pix        = pix_s0;
      s0.cur        = cur_s0;
      s0.ge1        = (row_norm != '0);
      s0.ge2        = (row_norm > CFG_W'(1));
      s0.col_zero   = (col_norm == '0);
      s0.last_col   = last_col;
      s0.last_frame = (row_norm == h_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store: one word per column, read at accept, written in stage 1
   // ------------------------------------------------------------------
   logic             s1_valid_ff;
   stage_type        s1_ff;
   logic [MEM_W-1:0] ram_rdata;
   logic [MEM_W-1:0] wr_data;
   logic             fwd_valid_ff, fwd_valid_in;
   logic [MEM_W-1:0] fwd_data_ff;

   dpd_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.col),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_norm),
      .rd_data (ram_rdata)
   );

   // a one-column frame reads the entry that stage 1 is writing: forward it
   assign fwd_valid_in = s1_valid_ff && accept && (s1_ff.col == col_norm);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= fwd_valid_in;
      end
      if (accept) begin
         s1_ff <= s0;
      end
      fwd_data_ff <= wr_data;
   end

   // ------------------------------------------------------------------
   // Stage 1: window update, write back, result generation
   // ------------------------------------------------------------------
   logic [8:0]       win_ff, win_in, win_base;
   logic [PIX_W-1:0] hold0_ff, hold0_in;
   logic [PIX_W-1:0] hold1_ff, hold1_in;
   logic [MEM_W-1:0] rd_word;
   logic             up1, up2;
   logic             push_a, push_b;
   result_type       res_a, res_b;
   logic [PIX_W-1:0] pix_a, pix_b;

   always_comb begin
      rd_word  = fwd_valid_ff ? fwd_data_ff : ram_rdata;
      up2      = s1_ff.ge2 && rd_word[0];
      up1      = s1_ff.ge1 && rd_word[1];

      // shift the window left one column, new column enters on the right
      win_base = s1_ff.col_zero ? 9'd0 : win_ff;
      win_in   = {s1_ff.cur, up1, up2, win_base[8:3]};

      hold0_in = hold1_ff;
      hold1_in = s1_ff.ge1 ? rd_word[MEM_W-1:2] : BLACK_PIXEL;

      // the row above moves down one place; this row becomes the row above
      wr_data  = {s1_ff.pix, s1_ff.cur, up1};

      pix_a = dilate_pixel(hold0_in, win_in);
      pix_b = dilate_pixel(hold1_in, {3'd0, win_in[8:3]});

      res_a.red_out       = pix_a[23:16];
      res_a.green_out     = pix_a[15:8];
      res_a.blue_out      = pix_a[7:0];
      res_a.last_of_run   = !s1_ff.last_col;
      res_a.last_of_frame = 1'b0;

      res_b.red_out       = pix_b[23:16];
      res_b.green_out     = pix_b[15:8];
      res_b.blue_out      = pix_b[7:0];
      res_b.last_of_run   = 1'b1;
      res_b.last_of_frame = s1_ff.last_frame;

      // row 0 yields nothing; the left column yields only its end-of-row result
      push_a = s1_valid_ff && s1_ff.ge1 && !s1_ff.col_zero;
      push_b = s1_valid_ff && s1_ff.ge1 && s1_ff.last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         hold0_ff <= BLACK_PIXEL;
         hold1_ff <= BLACK_PIXEL;
      end else if (s1_valid_ff) begin
         win_ff   <= win_in;
         hold0_ff <= hold0_in;
         hold1_ff <= hold1_in;
      end
   end

   // ------------------------------------------------------------------
   // Result queue: takes up to two beats a cycle, gives one
   // ------------------------------------------------------------------
   result_type  queue_ff [QDEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_in;
   logic [QW-1:0] slot_b;
   logic          pop;
   result_type    head;

   assign pop    = rsp.valid && rsp.ready;
   assign slot_b = wr_ptr_ff + QW'(push_a);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QW'(push_a) + QW'(push_b);
      rd_ptr_in = rd_ptr_ff + QW'(pop);
      count_in  = count_ff + (QW+1)'(push_a) + (QW+1)'(push_b) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_a) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (push_b) begin
         queue_ff[slot_b] <= res_b;
      end
   end

   assign head              = queue_ff[rd_ptr_ff];
   assign rsp.valid         = (count_ff != '0);
   assign rsp.red_out       = head.red_out;
   assign rsp.green_out     = head.green_out;
   assign rsp.blue_out      = head.blue_out;
   assign rsp.last_of_run   = head.last_of_run;
   assign rsp.last_of_frame = head.last_of_frame;

endmodule

### rtl/dpd_checker.sv
`timescale 1ns / 1ps
module dpd_checker import dpd_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [CH_W-1:0] rsp_red_out,
   input logic [CH_W-1:0] rsp_green_out,
   input logic [CH_W-1:0] rsp_blue_out,
   input logic            rsp_last_of_run,
   input logic            rsp_last_of_frame,
   input logic            csr_pready
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_red_out, rsp_green_out,
         rsp_blue_out, rsp_last_of_run, rsp_last_of_frame}))
      else $error("stalled result beat changed");

   // the frame's last pixel always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_run)
      else $error("last_of_frame without last_of_run");

   // a reset leaves no result beat in the queue
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a result stream starts only from an accepted input beat that has passed stage 1
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a causing input beat");

   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready dropped");

endmodule

bind dark_pixel_dilate_3x3_core dpd_checker u_dpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_red_out       (rsp.red_out),
   .rsp_green_out     (rsp.green_out),
   .rsp_blue_out      (rsp.blue_out),
   .rsp_last_of_run   (rsp.last_of_run),
   .rsp_last_of_frame (rsp.last_of_frame),
   .csr_pready        (csr_pready)
);
